/* design/pps_pkg.sv */
// Shared types and constants of the polygon plane split block.
package pps_pkg;

  localparam int COORD_W  = 32;   // Q16.16 coordinate
  localparam int NORM_W   = 18;   // Q2.16 normal component
  localparam int PROD_W   = 50;   // one normal * coordinate product
  localparam int DOT_W    = 51;   // sum of three products, signed
  localparam int MAG_W    = 50;   // magnitude of a dot product
  localparam int HALF_W   = 25;   // half of a magnitude, per partial product
  localparam int PPROD_W  = 57;   // HALF_W x COORD_W partial product
  localparam int NUM_W    = 84;   // weighted sum numerator
  localparam int VERT_W   = 96;   // x, y, z packed
  localparam int USER_W   = 4;

  localparam logic [1:0] REG_NORMAL_X = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [1:0] REG_NORMAL_Z = 2'd2;

  localparam logic [NORM_W-1:0]  NORMAL_Z_RESET = 18'd65536;
  localparam logic [COORD_W-1:0] SIGN_FLIP      = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_DOT, S_CLASS, S_EVAL, S_XRUN, S_XWAIT,
    S_XADD, S_ADDL, S_ADDC, S_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {X_IDLE, X_MUL, X_DIV, X_RND} cross_state_t;

  typedef struct packed {
    logic       store_wr;
    logic       dot_en;
    logic [1:0] dot_ph;
    logic       walk_init;
    logic       x_start;
    logic       x_save;
    logic       add_cross;
    logic       add_last;
    logic       add_cur;
    logic       advance;
    logic       split_done;
  } pps_cmd_t;

  typedef struct packed {
    logic few;
    logic change;
    logic wb_zero;
    logic x_done;
    logic e_last;
  } pps_status_t;

  // Magnitude of a dot product; always fits MAG_W bits.
  function automatic logic [MAG_W-1:0] dot_mag(input logic signed [DOT_W-1:0] d);
    logic signed [DOT_W-1:0] a;
    a = d[DOT_W-1] ? -d : d;
    return a[MAG_W-1:0];
  endfunction

endpackage

/* design/pps_cross.sv */
// Crossing point of one coordinate: rounded weighted average by an iterative divider.
module pps_cross (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pps_pkg::COORD_W-1:0] ua,
  input  logic [pps_pkg::COORD_W-1:0] ub,
  input  logic [pps_pkg::MAG_W-1:0]   wa,
  input  logic [pps_pkg::MAG_W-1:0]   wb,
  output logic [pps_pkg::COORD_W-1:0] result,
  output logic                        done
);
  import pps_pkg::*;

  cross_state_t         state, state_next;
  logic [2:0]           mcnt;
  logic [4:0]           dcnt;
  logic [PPROD_W-1:0]   prod;
  logic                 prod_hi;
  logic [NUM_W-1:0]     num, num_next;
  logic [DOT_W-1:0]     rem;
  logic [COORD_W-1:0]   low;
  logic [COORD_W-1:0]   quo;
  logic [DOT_W-1:0]     d;
  logic [DOT_W:0]       r2, diff;
  logic                 ge, rnd;
  logic [MAG_W-1:0]     wsel;
  logic [COORD_W-1:0]   usel;
  logic [HALF_W-1:0]    half;

  // Offset-binary operands, partial product select
  assign wsel = mcnt[1] ? wb : wa;
  assign usel = mcnt[1] ? (ub ^ SIGN_FLIP) : (ua ^ SIGN_FLIP);
  assign half = mcnt[0] ? wsel[MAG_W-1:HALF_W] : wsel[HALF_W-1:0];
  assign num_next = prod_hi ? num + NUM_W'({prod, {HALF_W{1'b0}}})
                            : num + NUM_W'(prod);

  // Divider step and rounding decision
  assign d    = DOT_W'(wa) + DOT_W'(wb);
  assign r2   = {rem, low[COORD_W-1]};
  assign diff = r2 - {1'b0, d};
  assign ge   = (r2 >= {1'b0, d});
  assign rnd  = (rem >= d - rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= X_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      X_IDLE:  if (start) state_next = X_MUL;
      X_MUL:   if (mcnt == 3'd4) state_next = X_DIV;
      X_DIV:   if (dcnt == 5'd31) state_next = X_RND;
      X_RND:   state_next = X_IDLE;
      default: state_next = X_IDLE;
    endcase
  end

  // Multiply-accumulate, then restoring division one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == X_RND);
    end
    case (state)
      X_IDLE: begin
        mcnt    <= 3'd0;
        num     <= '0;
        prod_hi <= 1'b0;
      end
      X_MUL: begin
        mcnt <= mcnt + 3'd1;
        if (mcnt != 3'd4) begin
          prod    <= PPROD_W'(half * usel);
          prod_hi <= mcnt[0];
        end
        if (mcnt != 3'd0) num <= num_next;
        if (mcnt == 3'd4) begin
          rem  <= num_next[NUM_W-2:COORD_W];
          low  <= num_next[COORD_W-1:0];
          dcnt <= 5'd0;
          quo  <= '0;
        end
      end
      X_DIV: begin
        rem  <= ge ? diff[DOT_W-1:0] : r2[DOT_W-1:0];
        low  <= {low[COORD_W-2:0], 1'b0};
        quo  <= {quo[COORD_W-2:0], ge};
        dcnt <= dcnt + 5'd1;
      end
      X_RND: begin
        result <= (quo + COORD_W'(rnd)) ^ SIGN_FLIP;
      end
      default: ;
    endcase
  end

endmodule

/* design/pps_datapath.sv */
// Datapath: vertex store, dot products, walk registers, crossing unit and pieces.
module pps_datapath #(
  parameter int VERT_CAP = 7,
  parameter int IW = $clog2(VERT_CAP),
  parameter int CW = $clog2(VERT_CAP + 2)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [pps_pkg::NORM_W-1:0]  cfg_data,
  input  logic [pps_pkg::VERT_W-1:0]  in_vert,
  input  pps_pkg::pps_cmd_t           cmd,
  input  logic [CW-1:0]               vi,
  input  logic [1:0]                  xc,
  input  logic                        esd,
  input  logic [IW-1:0]               ej,
  output pps_pkg::pps_status_t        st,
  output logic [CW-1:0]               vcount,
  output logic [pps_pkg::VERT_W-1:0]  out_vert,
  output logic                        out_empty,
  output logic                        out_ovf
);
  import pps_pkg::*;

  localparam logic [CW-1:0] MAXC = CW'(VERT_CAP);

  logic signed [NORM_W-1:0]  nx, ny, nz;
  logic [VERT_W-1:0]         store [VERT_CAP];
  logic signed [DOT_W-1:0]   dots  [VERT_CAP];
  logic                      lovf;

  logic signed [PROD_W-1:0]  prod;
  logic signed [DOT_W-1:0]   acc, dotv, mn, mx;
  logic [IW-1:0]             start;
  logic signed [NORM_W-1:0]  nsel;
  logic signed [COORD_W-1:0] csel;

  logic                      copy, cur, prev_side, cur_new;
  logic [VERT_W-1:0]         last_v, rv, pvert;
  logic signed [DOT_W-1:0]   last_dot, rdot;
  logic [CW:0]               wsum, wfull;
  logic [IW-1:0]             widx, ridx;
  logic                      neg, pos, cls_copy;

  logic [COORD_W-1:0]        xres;
  logic                      xdone;
  logic [COORD_W-1:0]        pc [3];

  logic [VERT_W-1:0]         piece0 [VERT_CAP];
  logic [VERT_W-1:0]         piece1 [VERT_CAP];
  logic [CW-1:0]             cnt0, cnt1, csel_n, neff;
  logic                      we0, we1;
  logic [VERT_W-1:0]         wd0, wd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= '0;
      ny <= '0;
      nz <= NORMAL_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X: nx <= cfg_data;
        REG_NORMAL_Y: ny <= cfg_data;
        REG_NORMAL_Z: nz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store read address: dot pass in load order, walk from the start vertex (vertex 0 when copying)
  assign wsum  = (CW+1)'(copy ? '0 : start) + (CW+1)'(vi);
  assign wfull = (wsum >= (CW+1)'(vcount)) ? wsum - (CW+1)'(vcount) : wsum;
  assign widx  = wfull[IW-1:0];
  assign ridx  = cmd.dot_en ? vi[IW-1:0] : widx;
  assign rv    = store[ridx];
  assign rdot  = dots[ridx];

  // Load vertices; drop beyond capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      lovf   <= 1'b0;
    end else if (cmd.split_done) begin
      vcount <= '0;
      lovf   <= 1'b0;
    end else if (cmd.store_wr) begin
      if (vcount < MAXC) vcount <= vcount + CW'(1);
      else lovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr && vcount < MAXC) store[vcount[IW-1:0]] <= in_vert;
  end

  // Dot products: one multiply a cycle, accumulate behind it
  always_comb begin
    case (cmd.dot_ph)
      2'd0:    begin nsel = nx; csel = rv[31:0];  end
      2'd1:    begin nsel = ny; csel = rv[63:32]; end
      default: begin nsel = nz; csel = rv[95:64]; end
    endcase
  end

  assign dotv = acc + prod;

  always_ff @(posedge clk) begin
    if (cmd.dot_en) begin
      prod <= nsel * csel;
      case (cmd.dot_ph)
        2'd1: acc <= DOT_W'(prod);
        2'd2: acc <= dotv;
        2'd3: begin
          dots[vi[IW-1:0]] <= dotv;
          if (vi == '0 || dotv < mn) begin
            mn    <= dotv;
            start <= vi[IW-1:0];
          end
          if (vi == '0 || dotv > mx) mx <= dotv;
        end
        default: ;
      endcase
    end
  end

  // Classification and walk state
  assign neg      = (mn < 0);
  assign pos      = (mx > 0);
  assign cls_copy = (neg && !pos) || (pos && !neg);
  assign cur_new  = copy ? cur : ((rdot < 0) ? 1'b0 : ((rdot > 0) ? 1'b1 : cur));

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      copy      <= cls_copy;
      cur       <= cls_copy && !neg;
      prev_side <= cls_copy && !neg;
      last_dot  <= '0;
    end else if (cmd.advance) begin
      last_v    <= rv;
      last_dot  <= rdot;
      prev_side <= cur_new;
      cur       <= cur_new;
    end
  end

  // Crossing point, one coordinate at a time
  pps_cross u_cross (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.x_start),
    .ua     (last_v[32*xc +: 32]),
    .ub     (rv[32*xc +: 32]),
    .wa     (dot_mag(rdot)),
    .wb     (dot_mag(last_dot)),
    .result (xres),
    .done   (xdone)
  );

  always_ff @(posedge clk) begin
    if (cmd.x_save) pc[xc] <= xres;
  end

  // Piece writes
  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wd0 = rv;
    wd1 = rv;
    if (cmd.add_cross) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wd0 = {pc[2], pc[1], pc[0]};
      wd1 = {pc[2], pc[1], pc[0]};
    end else if (cmd.add_last || cmd.add_cur) begin
      we0 = !cur_new;
      we1 = cur_new;
      wd0 = cmd.add_last ? last_v : rv;
      wd1 = cmd.add_last ? last_v : rv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.split_done) begin
      cnt0 <= '0;
      cnt1 <= '0;
    end else begin
      if (we0 && cnt0 <= MAXC) cnt0 <= cnt0 + CW'(1);
      if (we1 && cnt1 <= MAXC) cnt1 <= cnt1 + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we0 && cnt0 < MAXC) piece0[cnt0[IW-1:0]] <= wd0;
    if (we1 && cnt1 < MAXC) piece1[cnt1[IW-1:0]] <= wd1;
  end

  // Emit side
  assign csel_n    = esd ? cnt1 : cnt0;
  assign neff      = (csel_n > MAXC) ? MAXC : csel_n;
  assign pvert     = esd ? piece1[ej] : piece0[ej];
  assign out_empty = (neff == '0);
  assign out_ovf   = !out_empty && (csel_n > MAXC || lovf);
  assign out_vert  = out_empty ? '0 : pvert;

  assign st.few     = (vcount < CW'(3));
  assign st.change  = (cur_new != prev_side);
  assign st.wb_zero = (last_dot == '0);
  assign st.x_done  = xdone;
  assign st.e_last  = out_empty || (CW'(ej) + CW'(1) == neff);

endmodule

/* design/pps_ctrl.sv */
// Controller: sequences load, dot pass, walk, crossings and emit.
module pps_ctrl #(
  parameter int VERT_CAP = 7,
  parameter int IW = $clog2(VERT_CAP),
  parameter int CW = $clog2(VERT_CAP + 2)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CW-1:0]        vcount,
  input  pps_pkg::pps_status_t st,
  output pps_pkg::pps_cmd_t    cmd,
  output logic [CW-1:0]        vi,
  output logic [1:0]           xc,
  output logic                 esd,
  output logic [IW-1:0]        ej
);
  import pps_pkg::*;

  ctrl_state_t   state, state_next;
  logic [CW-1:0] vi_next;
  logic [1:0]    ph, ph_next, xc_next;
  logic          esd_next;
  logic [IW-1:0] ej_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      vi    <= '0;
      ph    <= '0;
      xc    <= '0;
      esd   <= 1'b0;
      ej    <= '0;
    end else begin
      state <= state_next;
      vi    <= vi_next;
      ph    <= ph_next;
      xc    <= xc_next;
      esd   <= esd_next;
      ej    <= ej_next;
    end
  end

  always_comb begin
    state_next = state;
    vi_next    = vi;
    ph_next    = ph;
    xc_next    = xc;
    esd_next   = esd;
    ej_next    = ej;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      // Take vertices until the closing one
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_wr = 1'b1;
          if (in_last) state_next = S_START;
        end
      end
      S_START: begin
        vi_next = '0;
        ph_next = '0;
        if (st.few) begin
          esd_next   = 1'b0;
          ej_next    = '0;
          state_next = S_EMIT;
        end else begin
          state_next = S_DOT;
        end
      end
      // Multiply x, y and z in turn, then store the dot product
      S_DOT: begin
        cmd.dot_en = 1'b1;
        cmd.dot_ph = ph;
        ph_next    = ph + 2'd1;
        if (ph == 2'd3) begin
          if (CW'(vi + CW'(1)) == vcount) begin
            vi_next    = '0;
            state_next = S_CLASS;
          end else begin
            vi_next = vi + CW'(1);
          end
        end
      end
      S_CLASS: begin
        cmd.walk_init = 1'b1;
        state_next    = S_EVAL;
      end
      // Decide what a side change inserts
      S_EVAL: begin
        if (st.change && !st.wb_zero) begin
          xc_next    = 2'd0;
          state_next = S_XRUN;
        end else if (st.change) begin
          state_next = S_ADDL;
        end else begin
          state_next = S_ADDC;
        end
      end
      S_XRUN: begin
        cmd.x_start = 1'b1;
        state_next  = S_XWAIT;
      end
      S_XWAIT: begin
        if (st.x_done) begin
          cmd.x_save = 1'b1;
          if (xc == 2'd2) begin
            state_next = S_XADD;
          end else begin
            xc_next    = xc + 2'd1;
            state_next = S_XRUN;
          end
        end
      end
      S_XADD: begin
        cmd.add_cross = 1'b1;
        state_next    = S_ADDC;
      end
      S_ADDL: begin
        cmd.add_last = 1'b1;
        state_next   = S_ADDC;
      end
      // Add the current vertex and advance; the closing step only checks the edge
      S_ADDC: begin
        cmd.advance = 1'b1;
        if (vi == vcount) begin
          esd_next   = 1'b0;
          ej_next    = '0;
          state_next = S_EMIT;
        end else begin
          cmd.add_cur = 1'b1;
          vi_next     = vi + CW'(1);
          state_next  = S_EVAL;
        end
      end
      // One result per transfer, negative piece first
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.e_last) begin
            if (esd) begin
              cmd.split_done = 1'b1;
              state_next     = S_LOAD;
            end else begin
              esd_next = 1'b1;
              ej_next  = '0;
            end
          end else begin
            ej_next = ej + IW'(1);
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");
  a_done_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.split_done |=> (state == S_LOAD))
    else $error("split end did not return to load");
  a_xdone_waited: assert property (@(posedge clk) disable iff (rst)
    st.x_done |-> (state == S_XWAIT))
    else $error("crossing result outside wait");
`endif

endmodule

/* design/polygon_plane_split.sv */
// Top level of the polygon plane split block.
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata x,y,z; tlast final vertex
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata x,y,z; tlast end of piece
//  cfg       | in        | cfg_we                       | cfg_index, cfg_data
//
// Vertices load one per cycle while input is open. The final vertex is followed by a setup step,
// the dot products of every stored vertex (one shared multiplier) and a classify step.
// A walk step passes the evaluate and add-current states, plus add-last when an on-plane vertex
// is repeated; a crossing runs the iterative divider for each coordinate, then an insert step.
// Results then leave one per transfer; input is held off until the last one is transferred.
// Reset is synchronous and clears control state; no clearing pass is needed.
module polygon_plane_split #(
  parameter int VERT_CAP = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [pps_pkg::NORM_W-1:0]  cfg_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [pps_pkg::VERT_W-1:0]  s_axis_tdata,   // vert_x, vert_y, vert_z
  input  logic                        s_axis_tlast,   // final_vertex
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [pps_pkg::VERT_W-1:0]  m_axis_tdata,   // out_x, out_y, out_z
  output logic [pps_pkg::USER_W-1:0]  m_axis_tuser,   // piece_side, piece_empty,
                                                      // piece_overflow, last_of_split
  output logic                        m_axis_tlast    // last_of_piece
);
  import pps_pkg::*;

  localparam int IW = $clog2(VERT_CAP);
  localparam int CW = $clog2(VERT_CAP + 2);

  pps_cmd_t      cmd;
  pps_status_t   st;
  logic [CW-1:0] vcount, vi;
  logic [1:0]    xc;
  logic          esd, o_empty, o_ovf;
  logic [IW-1:0] ej;

  pps_ctrl #(.VERT_CAP(VERT_CAP), .IW(IW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .vcount    (vcount),
    .st        (st),
    .cmd       (cmd),
    .vi        (vi),
    .xc        (xc),
    .esd       (esd),
    .ej        (ej)
  );

  pps_datapath #(.VERT_CAP(VERT_CAP), .IW(IW), .CW(CW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_vert   (s_axis_tdata),
    .cmd       (cmd),
    .vi        (vi),
    .xc        (xc),
    .esd       (esd),
    .ej        (ej),
    .st        (st),
    .vcount    (vcount),
    .out_vert  (m_axis_tdata),
    .out_empty (o_empty),
    .out_ovf   (o_ovf)
  );

  // Pack result flags
  assign m_axis_tlast = st.e_last;
  assign m_axis_tuser = {st.e_last && esd, o_ovf, o_empty, esd};

endmodule
